// ===== sv/v3a_pkg.sv =====
// Shared types, opcodes and saturation helper for the three-component vector ALU.
// No dependencies; every other file imports this package.
package v3a_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_SCALE = 4'd2;
  localparam logic [3:0] OP_DIV   = 4'd3;
  localparam logic [3:0] OP_DOT   = 4'd4;
  localparam logic [3:0] OP_CROSS = 4'd5;
  localparam logic [3:0] OP_MAG   = 4'd6;
  localparam logic [3:0] OP_NORM  = 4'd7;
  localparam logic [3:0] OP_EQ    = 4'd8;
  localparam logic [3:0] OP_NE    = 4'd9;

  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

  typedef logic [31:0] word_t;
  typedef word_t [2:0] vec_t;

  // Item state carried down the pipeline
  typedef struct packed {
    logic [3:0] op;
    vec_t       vec;   // finished vector, or |a| for divide and normalize
    word_t      scl;
    logic       cmp;
    logic [2:0] neg;   // quotient sign per lane
    word_t      dvs;   // |scalar| for divide
    logic       err;
  } mid_t;

  typedef struct packed {
    logic  err;
    logic  cmp;
    word_t scl;
    vec_t  vec;
  } res_t;

  function automatic word_t sat_q(input logic signed [65:0] v);
    word_t r;
    if (v > SAT_HI) begin
      r = 32'h7FFF_FFFF;
    end else if (v < SAT_LO) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/v3a_mul_pipe.sv =====
// Front end of the vector ALU: input register, six shared multipliers, sums and rescale.
// Depends on v3a_pkg.
module v3a_mul_pipe
  import v3a_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        ce,
  input  logic        in_vld,
  input  logic [3:0]  in_op,
  input  vec_t        in_a,
  input  vec_t        in_b,
  input  word_t       in_s,
  output logic        out_vld,
  output mid_t        out_mid,
  output logic [63:0] out_sumsq
);

  // stage 0
  logic       v0_r;
  logic [3:0] op0_r;
  vec_t       a0_r, b0_r;
  word_t      s0_r;

  // stage 1
  logic              v1_r;
  mid_t              c1_r, c1_nxt;
  logic signed [63:0] p_r [6];
  logic signed [63:0] p_nxt [6];
  logic signed [31:0] ml [6];
  logic signed [31:0] mr [6];

  // stage 2
  logic               v2_r;
  mid_t               c2_r;
  logic signed [64:0] w_r [3];
  logic signed [64:0] w_nxt [3];
  logic signed [65:0] dsum_r, dsum_nxt;

  // stage 3
  logic        v3_r;
  mid_t        c3_r, c3_nxt;
  logic [63:0] sumsq_r;
  logic signed [64:0] sh_w [3];
  logic signed [65:0] sh_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (ce) begin
      v0_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      op0_r <= in_op;
      a0_r  <= in_a;
      b0_r  <= in_b;
      s0_r  <= in_s;
    end
  end

  // operand routing for the six multipliers
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      ml[k] = '0;
      mr[k] = '0;
    end
    if (op0_r == OP_CROSS) begin
      ml[0] = $signed(a0_r[1]); mr[0] = $signed(b0_r[2]);
      ml[1] = $signed(a0_r[2]); mr[1] = $signed(b0_r[1]);
      ml[2] = $signed(a0_r[2]); mr[2] = $signed(b0_r[0]);
      ml[3] = $signed(a0_r[0]); mr[3] = $signed(b0_r[2]);
      ml[4] = $signed(a0_r[0]); mr[4] = $signed(b0_r[1]);
      ml[5] = $signed(a0_r[1]); mr[5] = $signed(b0_r[0]);
    end else begin
      for (int i = 0; i < 3; i++) begin
        ml[2*i] = $signed(a0_r[i]);
        if (op0_r == OP_SCALE) begin
          mr[2*i] = $signed(s0_r);
        end else if (op0_r == OP_DOT) begin
          mr[2*i] = $signed(b0_r[i]);
        end else begin
          mr[2*i] = $signed(a0_r[i]);
        end
      end
    end
    for (int k = 0; k < 6; k++) begin
      p_nxt[k] = ml[k] * mr[k];
    end
  end

  always_comb begin
    logic signed [32:0] sum;
    logic               eq;
    c1_nxt     = '0;
    c1_nxt.op  = op0_r;
    c1_nxt.dvs = s0_r[31] ? (~s0_r + 32'd1) : s0_r;
    eq         = (a0_r == b0_r);
    for (int i = 0; i < 3; i++) begin
      if (op0_r == OP_SUB) begin
        sum = {a0_r[i][31], a0_r[i]} - {b0_r[i][31], b0_r[i]};
      end else begin
        sum = {a0_r[i][31], a0_r[i]} + {b0_r[i][31], b0_r[i]};
      end
      if (op0_r == OP_ADD || op0_r == OP_SUB) begin
        c1_nxt.vec[i] = sat_q({{33{sum[32]}}, sum});
      end else if (op0_r == OP_DIV || op0_r == OP_NORM) begin
        c1_nxt.vec[i] = a0_r[i][31] ? (~a0_r[i] + 32'd1) : a0_r[i];
      end
      c1_nxt.neg[i] = a0_r[i][31] ^ ((op0_r == OP_DIV) & s0_r[31]);
    end
    c1_nxt.err = (op0_r == OP_DIV) && (s0_r == '0);
    c1_nxt.cmp = ((op0_r == OP_EQ) & eq) | ((op0_r == OP_NE) & ~eq);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (c1_r.op == OP_CROSS) begin
        w_nxt[i] = {p_r[2*i][63], p_r[2*i]} - {p_r[2*i+1][63], p_r[2*i+1]};
      end else begin
        w_nxt[i] = {p_r[2*i][63], p_r[2*i]};
      end
    end
    dsum_nxt = {{2{p_r[0][63]}}, p_r[0]} + {{2{p_r[2][63]}}, p_r[2]}
             + {{2{p_r[4][63]}}, p_r[4]};
  end

  // floor rescale and saturate
  always_comb begin
    c3_nxt = c2_r;
    for (int i = 0; i < 3; i++) begin
      sh_w[i] = w_r[i] >>> FRAC_BITS;
      if (c2_r.op == OP_SCALE || c2_r.op == OP_CROSS) begin
        c3_nxt.vec[i] = sat_q({sh_w[i][64], sh_w[i]});
      end
    end
    sh_d = dsum_r >>> FRAC_BITS;
    if (c2_r.op == OP_DOT) begin
      c3_nxt.scl = sat_q(sh_d);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (ce) begin
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      c1_r <= c1_nxt;
      for (int k = 0; k < 6; k++) begin
        p_r[k] <= p_nxt[k];
      end
      c2_r <= c1_r;
      for (int i = 0; i < 3; i++) begin
        w_r[i] <= w_nxt[i];
      end
      dsum_r  <= dsum_nxt;
      c3_r    <= c3_nxt;
      sumsq_r <= dsum_r[63:0];
    end
  end

  assign out_vld   = v3_r;
  assign out_mid   = c3_r;
  assign out_sumsq = sumsq_r;

endmodule

// ===== sv/v3a_sqrt_pipe.sv =====
// Pipelined integer square root of a 64-bit sum of squares, one root bit per stage.
// Depends on v3a_pkg.
module v3a_sqrt_pipe
  import v3a_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        ce,
  input  logic        in_vld,
  input  logic [63:0] in_sum,
  input  mid_t        in_mid,
  output logic        out_vld,
  output word_t       out_root,
  output mid_t        out_mid
);

  localparam int unsigned NS = 32;

  logic        vld_r  [NS];
  logic [33:0] rem_r  [NS];
  logic [33:0] rem_nxt [NS];
  word_t       root_r [NS];
  word_t       root_nxt [NS];
  logic [63:0] n_r    [NS];
  mid_t        mid_r  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic        vld_src;
    logic [33:0] rem_src;
    word_t       root_src;
    logic [63:0] n_src;
    mid_t        mid_src;
    logic [35:0] rin;
    logic [35:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign vld_src  = in_vld;
      assign rem_src  = '0;
      assign root_src = '0;
      assign n_src    = in_sum;
      assign mid_src  = in_mid;
    end else begin : g_next
      assign vld_src  = vld_r[k-1];
      assign rem_src  = rem_r[k-1];
      assign root_src = root_r[k-1];
      assign n_src    = n_r[k-1];
      assign mid_src  = mid_r[k-1];
    end

    assign rin         = {rem_src, n_src[63:62]};
    assign trial       = {2'b00, root_src, 2'b01};
    assign ge          = (rin >= trial);
    assign rem_nxt[k]  = ge ? 34'(rin - trial) : rin[33:0];
    assign root_nxt[k] = {root_src[30:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ce) begin
        vld_r[k] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        n_r[k]    <= {n_src[61:0], 2'b00};
        mid_r[k]  <= mid_src;
      end
    end
  end

  assign out_vld  = vld_r[NS-1];
  assign out_root = root_r[NS-1];
  assign out_mid  = mid_r[NS-1];

endmodule

// ===== sv/v3a_div_pipe.sv =====
// Three-lane pipelined restoring divider: (num << FRAC_BITS) / den, one quotient bit per stage.
// Depends on v3a_pkg.
module v3a_div_pipe
  import v3a_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  localparam int unsigned QW = 32 + FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ce,
  input  logic                  in_vld,
  input  vec_t                  in_num,
  input  word_t                 in_den,
  input  mid_t                  in_mid,
  output logic                  out_vld,
  output logic [2:0][QW-1:0]    out_quo,
  output mid_t                  out_mid
);

  logic               vld_r [QW];
  word_t              den_r [QW];
  mid_t               mid_r [QW];
  logic [2:0][31:0]   rem_r [QW];
  logic [2:0][31:0]   rem_nxt [QW];
  logic [2:0][QW-1:0] x_r   [QW];
  logic [2:0][QW-1:0] x_nxt [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic               vld_src;
    word_t              den_src;
    mid_t               mid_src;
    logic [2:0][31:0]   rem_src;
    logic [2:0][QW-1:0] x_src;

    if (k == 0) begin : g_first
      assign vld_src = in_vld;
      assign den_src = in_den;
      assign mid_src = in_mid;
      assign rem_src = '0;
      for (genvar i = 0; i < 3; i++) begin : g_load
        assign x_src[i] = {in_num[i], {FRAC_BITS{1'b0}}};
      end
    end else begin : g_next
      assign vld_src = vld_r[k-1];
      assign den_src = den_r[k-1];
      assign mid_src = mid_r[k-1];
      assign rem_src = rem_r[k-1];
      assign x_src   = x_r[k-1];
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [32:0] rin;
      logic        ge;
      assign rin           = {rem_src[i], x_src[i][QW-1]};
      assign ge            = (rin >= {1'b0, den_src});
      assign rem_nxt[k][i] = ge ? 32'(rin - {1'b0, den_src}) : rin[31:0];
      assign x_nxt[k][i]   = {x_src[i][QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ce) begin
        vld_r[k] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        den_r[k] <= den_src;
        mid_r[k] <= mid_src;
        rem_r[k] <= rem_nxt[k];
        x_r[k]   <= x_nxt[k];
      end
    end
  end

  assign out_vld = vld_r[QW-1];
  assign out_quo = x_r[QW-1];
  assign out_mid = mid_r[QW-1];

endmodule

// ===== sv/vector3_alu_unit.sv =====
// Top level of the three-component Q16.16 vector ALU: pipeline and two-entry output queue.
// Depends on v3a_pkg, v3a_mul_pipe, v3a_sqrt_pipe and v3a_div_pipe.
//
// One item is accepted per clock while in_tready is high and one result item leaves per
// item, in order. Every operation takes the same path: four stages of input capture,
// multiply and rescale, a 32-stage square root (one root bit per stage) and a
// (32 + FRAC_BITS)-stage divider (one quotient bit per stage), then a two-entry output
// queue. The whole pipeline holds when the output queue is full; in_tready falls only
// then.
module vector3_alu_unit
  import v3a_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [223:0] in_tdata,   // ax, ay, az, bx, by_comp, bz, scalar_in
  input  logic [3:0]   in_tuser,   // opcode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata   // rx, ry, rz, scalar_out, compare_flag, divide_error
);

  localparam int unsigned QW = 32 + FRAC_BITS;
  localparam logic [QW-1:0] QPOS = QW'(33'h0_7FFF_FFFF);
  localparam logic [QW-1:0] QNEG = QW'(33'h0_8000_0000);

  logic        ce;
  vec_t        in_a, in_b;
  logic        mp_vld;
  mid_t        mp_mid;
  logic [63:0] mp_sumsq;
  logic        sq_vld;
  word_t       sq_root;
  mid_t        sq_mid;
  mid_t        dv_in_mid;
  word_t       dv_den;
  logic        dv_vld;
  logic [2:0][QW-1:0] dv_quo;
  mid_t        dv_mid;
  res_t        fin;

  res_t        ent_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push, pop;
  res_t        head;

  assign in_a = {in_tdata[95:64], in_tdata[63:32], in_tdata[31:0]};
  assign in_b = {in_tdata[191:160], in_tdata[159:128], in_tdata[127:96]};

  assign ce        = (cnt_r != 2'd2);
  assign in_tready = ce;

  v3a_mul_pipe #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_vld    (in_tvalid),
    .in_op     (in_tuser),
    .in_a      (in_a),
    .in_b      (in_b),
    .in_s      (in_tdata[223:192]),
    .out_vld   (mp_vld),
    .out_mid   (mp_mid),
    .out_sumsq (mp_sumsq)
  );

  v3a_sqrt_pipe u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_vld   (mp_vld),
    .in_sum   (mp_sumsq),
    .in_mid   (mp_mid),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_mid  (sq_mid)
  );

  // magnitude result, normalize error flag and divisor choice
  always_comb begin
    dv_in_mid = sq_mid;
    if (sq_mid.op == OP_MAG) begin
      dv_in_mid.scl = sq_root[31] ? 32'h7FFF_FFFF : sq_root;
    end
    if (sq_mid.op == OP_NORM) begin
      dv_in_mid.err = (sq_root == '0);
    end
    dv_den = (sq_mid.op == OP_DIV) ? sq_mid.dvs : sq_root;
  end

  v3a_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ce      (ce),
    .in_vld  (sq_vld),
    .in_num  (sq_mid.vec),
    .in_den  (dv_den),
    .in_mid  (dv_in_mid),
    .out_vld (dv_vld),
    .out_quo (dv_quo),
    .out_mid (dv_mid)
  );

  // sign and saturate quotients, or zero them on error
  always_comb begin
    fin.err = dv_mid.err;
    fin.cmp = dv_mid.cmp;
    fin.scl = dv_mid.scl;
    fin.vec = dv_mid.vec;
    if (dv_mid.op == OP_DIV || dv_mid.op == OP_NORM) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_mid.err) begin
          fin.vec[i] = '0;
        end else if (!dv_mid.neg[i]) begin
          fin.vec[i] = (dv_quo[i] > QPOS) ? 32'h7FFF_FFFF : dv_quo[i][31:0];
        end else begin
          fin.vec[i] = (dv_quo[i] > QNEG) ? 32'h8000_0000 : (~dv_quo[i][31:0] + 32'd1);
        end
      end
    end
  end

  assign push = ce & dv_vld;
  assign pop  = out_tvalid & out_tready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= fin;
    end
  end

  assign head       = ent_r[rp_r];
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {6'd0, head.err, head.cmp, head.scl, head.vec};

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && cnt_r == 2'd2))
    else $error("item pushed into full output queue");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && head.err |-> head.vec == '0 && head.scl == '0 && !head.cmp)
    else $error("divide error with nonzero result");

  a_cmp_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && head.cmp |-> head.vec == '0 && head.scl == '0)
    else $error("compare result with nonzero data");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push)
    else $error("pipeline advanced while queue full");

endmodule
